[src/emps_pkg.sv]
// ----------------------------------------------------------------------------
// emps_pkg
// Shared widths, codes, reset values and control structs for the eased
// motion profile sequencer.
// ----------------------------------------------------------------------------
package emps_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int POS_W      = 32;
    localparam int SPEED_W    = 16;
    localparam int DIST_W     = 24;
    localparam int TEN_W      = 28;   // holds 10 * traveled and 9 * distance
    localparam int FACT_W     = 17;   // Q1.16 easing factor, 0..65536
    localparam int PROD_W     = SPEED_W + FACT_W;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;

    // Default quarter-wave table depth
    localparam int DEF_SINE_TABLE_DEPTH = 256;

    // Fixed-point constants
    localparam logic [63:0]       PI_HALF_Q30 = 64'd1686629713;
    localparam logic [FACT_W-1:0] Q16_ONE     = 17'h10000;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_STARTUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE         = 3'd4;

    // Configuration reset values
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED     = 16'd900;
    localparam logic [SPEED_W-1:0] RST_MIN_SPEED     = 16'd400;
    localparam logic [DIST_W-1:0]  RST_TRAVEL        = 24'd72000;
    localparam logic [15:0]        RST_STARTUP_DELAY = 16'd500;
    localparam logic [15:0]        RST_PAUSE         = 16'd2000;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic start_move;
        logic arrive;
        logic hold;
        logic calc_trav;
        logic calc_prog;
        logic calc_zone;
        logic div_start;
        logic rom_rd;
        logic mul;
        logic finish;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              expired;
        logic              arrived;
        logic              zone_direct;
        logic              div_busy;
        logic              out_free;
    } t_dp_sts;

endpackage

[src/emps_div.sv]
// ----------------------------------------------------------------------------
// emps_div
// Restoring divider, one quotient bit per cycle, for quotients known to fit
// in QUOT_W bits (numerator below denominator times two to the QUOT_W).
// ----------------------------------------------------------------------------
module emps_div #(
    parameter int QUOT_W = 9,
    parameter int DEN_W  = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [QUOT_W+DEN_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_busy,
    output logic [QUOT_W-1:0]       o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quot;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] trial_sub;
    logic           trial_ge;

    // Shift the next numerator bit into the partial remainder
    assign trial     = {r_rem, r_low[QUOT_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign trial_ge  = (trial >= {1'b0, r_den});

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(QUOT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[QUOT_W +: DEN_W];
            r_low  <= i_num[QUOT_W-1:0];
            r_quot <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_rem  <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            r_low  <= {r_low[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], trial_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

[src/emps_sine_rom.sv]
// ----------------------------------------------------------------------------
// emps_sine_rom
// Quarter-wave sine table in Q1.16 with registered read. Entry i holds
// sin(pi/2 * i / DEPTH); addresses above DEPTH read the last entry.
// ----------------------------------------------------------------------------
module emps_sine_rom #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_addr,
    output logic [emps_pkg::FACT_W-1:0] o_data
);

    import emps_pkg::*;

    localparam int ROM_N = 2 ** ADDR_W;

    typedef logic [FACT_W-1:0] t_rom [ROM_N];

    // Nine-term Taylor series in Q2.30 with truncating steps
    function automatic logic [FACT_W-1:0] sine_entry(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        int unsigned k_idx;
        k_idx = (idx > DEPTH) ? DEPTH : idx;
        x     = (64'(k_idx) * PI_HALF_Q30) / 64'(DEPTH);
        term  = x;
        sum   = x;
        term  = (((term * x) >> 30) * x) >> 30;
        term  = term / 64'd6;
        sum   = (term > sum) ? 64'd0 : sum - term;
        term  = (((term * x) >> 30) * x) >> 30;
        term  = term / 64'd20;
        sum   = sum + term;
        term  = (((term * x) >> 30) * x) >> 30;
        term  = term / 64'd42;
        sum   = (term > sum) ? 64'd0 : sum - term;
        term  = (((term * x) >> 30) * x) >> 30;
        term  = term / 64'd72;
        sum   = sum + term;
        term  = (((term * x) >> 30) * x) >> 30;
        term  = term / 64'd110;
        sum   = (term > sum) ? 64'd0 : sum - term;
        term  = (((term * x) >> 30) * x) >> 30;
        term  = term / 64'd156;
        sum   = sum + term;
        term  = (((term * x) >> 30) * x) >> 30;
        term  = term / 64'd210;
        sum   = (term > sum) ? 64'd0 : sum - term;
        term  = (((term * x) >> 30) * x) >> 30;
        term  = term / 64'd272;
        sum   = sum + term;
        // Round half up to Q16 and cap at one
        r = (sum + 64'd8192) >> 14;
        return (r > 64'(Q16_ONE)) ? Q16_ONE : r[FACT_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < ROM_N; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [FACT_W-1:0] r_data;

    // Registered table read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

[src/emps_dp.sv]
// ----------------------------------------------------------------------------
// emps_dp
// Datapath: configuration registers, mode state, progress and zone math,
// divider, sine table, speed multiply and the output register.
// ----------------------------------------------------------------------------
module emps_dp #(
    parameter int SINE_TABLE_DEPTH = emps_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item
    input  logic [emps_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // result item
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [emps_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser,
    // configuration writes
    input  logic                              i_cfg_wr_en,
    input  logic [emps_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [emps_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    // controller link
    input  emps_pkg::t_dp_cmd                 i_cmd,
    output emps_pkg::t_dp_sts                 o_sts
);

    import emps_pkg::*;

    localparam int QW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int NUM_W = TEN_W + QW;
    localparam logic [QW-1:0] DEPTH_Q = QW'(SINE_TABLE_DEPTH);

    typedef enum logic [1:0] {
        ZONE_NONE   = 2'd0,
        ZONE_ACCEL  = 2'd1,
        ZONE_DECEL  = 2'd2,
        ZONE_CRUISE = 2'd3
    } t_zone;

    // Configuration
    logic [SPEED_W-1:0] r_max_speed;
    logic [SPEED_W-1:0] r_min_speed;
    logic [DIST_W-1:0]  r_travel;
    logic [15:0]        r_startup_delay;
    logic [15:0]        r_pause;

    // Sequencer state
    logic [MODE_W-1:0]  r_mode;
    logic [TIME_W-1:0]  r_entry;
    logic [POS_W-1:0]   r_start;
    logic [POS_W-1:0]   r_target;
    logic [DIST_W-1:0]  r_dist;
    logic [COUNT_W-1:0] r_cycles;

    // Captured item
    logic [TIME_W-1:0]  r_now;
    logic [POS_W-1:0]   r_pos;

    // Working registers
    logic signed [POS_W:0] r_trav;
    logic [TEN_W-1:0]      r_ten_t;
    logic [TEN_W-1:0]      r_nine_d;
    t_zone                 r_zone;
    logic [TEN_W-1:0]      r_sel;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_diff_neg;
    logic                  r_wr;
    logic [SPEED_W-1:0]    r_val;

    // Output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                  r_m_user;

    logic [TIME_W-1:0]  elapsed;
    logic [15:0]        delay;
    logic [DIST_W-1:0]  trav_clamp;
    t_zone              zone_nx;
    logic [TEN_W-1:0]   sel_nx;
    logic [NUM_W-1:0]   div_num;
    logic               div_busy;
    logic [QW-1:0]      quot;
    logic [QW-1:0]      rom_addr;
    logic [FACT_W-1:0]  rom_data;
    logic [FACT_W-1:0]  factor;
    logic [SPEED_W-1:0] diff_mag;
    logic [SPEED_W-1:0] ease_mag;

    // Mode timers
    assign elapsed = r_now - r_entry;
    assign delay   = (r_mode == MODE_STARTUP) ? r_startup_delay : r_pause;

    // Clamp traveled distance to the move
    always_comb begin
        if (r_trav <= 0) begin
            trav_clamp = '0;
        end else if (r_trav > $signed({9'b0, r_dist})) begin
            trav_clamp = r_dist;
        end else begin
            trav_clamp = r_trav[DIST_W-1:0];
        end
    end

    // Pick the easing zone
    always_comb begin
        zone_nx = ZONE_CRUISE;
        sel_nx  = r_ten_t;
        if (r_dist == '0) begin
            zone_nx = ZONE_NONE;
        end else if (r_ten_t < TEN_W'(r_dist)) begin
            zone_nx = ZONE_ACCEL;
        end else if (r_ten_t > r_nine_d) begin
            zone_nx = ZONE_DECEL;
            sel_nx  = r_ten_t - r_nine_d;
        end
    end

    // Table index scaled by depth, quotient by distance
    assign div_num = NUM_W'(r_sel) * NUM_W'(DEPTH_Q);

    emps_div #(
        .QUOT_W (QW),
        .DEN_W  (DIST_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num[QW+DIST_W-1:0]),
        .i_den   (r_dist),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // Mirror the index for the decel zone
    assign rom_addr = (r_zone == ZONE_ACCEL) ? quot
                    : DEPTH_Q - ((quot > DEPTH_Q) ? DEPTH_Q : quot);

    emps_sine_rom #(
        .DEPTH  (SINE_TABLE_DEPTH),
        .ADDR_W (QW)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (i_cmd.rom_rd),
        .i_addr  (rom_addr),
        .o_data  (rom_data)
    );

    // Easing factor and speed span
    always_comb begin
        case (r_zone)
            ZONE_CRUISE: factor = Q16_ONE;
            ZONE_NONE:   factor = '0;
            default:     factor = rom_data;
        endcase
    end

    assign diff_mag = (r_max_speed < r_min_speed) ? (r_min_speed - r_max_speed)
                                                  : (r_max_speed - r_min_speed);
    assign ease_mag = r_prod[PROD_W-2:FACT_W-1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed     <= RST_MAX_SPEED;
            r_min_speed     <= RST_MIN_SPEED;
            r_travel        <= RST_TRAVEL;
            r_startup_delay <= RST_STARTUP_DELAY;
            r_pause         <= RST_PAUSE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_MAX_SPEED:     r_max_speed     <= i_cfg_wr_data[SPEED_W-1:0];
                CFG_MIN_SPEED:     r_min_speed     <= i_cfg_wr_data[SPEED_W-1:0];
                CFG_TRAVEL:        r_travel        <= i_cfg_wr_data[DIST_W-1:0];
                CFG_STARTUP_DELAY: r_startup_delay <= i_cfg_wr_data[15:0];
                CFG_PAUSE:         r_pause         <= i_cfg_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Mode, move window and cycle count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_STARTUP;
            r_entry  <= '0;
            r_start  <= '0;
            r_target <= '0;
            r_dist   <= '0;
            r_cycles <= '0;
        end else if (i_cmd.start_move) begin
            r_mode   <= MODE_MOVING;
            r_entry  <= r_now;
            r_start  <= r_pos;
            r_target <= r_pos + POS_W'(r_travel);
            r_dist   <= r_travel;
        end else if (i_cmd.arrive) begin
            r_mode   <= MODE_PAUSED;
            r_entry  <= r_now;
            r_cycles <= r_cycles + 1'b1;
        end
    end

    // Item capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_s_tdata[TIME_W-1:0];
            r_pos <= i_s_tdata[TIME_W +: POS_W];
        end
        if (i_cmd.calc_trav) begin
            r_trav <= $signed({r_pos[POS_W-1], r_pos}) - $signed({r_start[POS_W-1], r_start});
        end
        if (i_cmd.calc_prog) begin
            r_ten_t  <= TEN_W'({trav_clamp, 3'b0}) + TEN_W'({trav_clamp, 1'b0});
            r_nine_d <= TEN_W'({r_dist, 3'b0}) + TEN_W'(r_dist);
        end
        if (i_cmd.calc_zone) begin
            r_zone <= zone_nx;
            r_sel  <= sel_nx;
        end
        if (i_cmd.mul) begin
            r_prod     <= PROD_W'(diff_mag) * PROD_W'(factor);
            r_diff_neg <= (r_max_speed < r_min_speed);
        end
        // Result fields
        if (i_cmd.start_move || i_cmd.hold) begin
            r_wr  <= 1'b0;
            r_val <= '0;
        end else if (i_cmd.arrive) begin
            r_wr  <= 1'b1;
            r_val <= '0;
        end else if (i_cmd.finish) begin
            r_wr  <= 1'b1;
            r_val <= r_diff_neg ? (r_min_speed - ease_mag) : (r_min_speed + ease_mag);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_m_data <= {{(OUT_DATA_W - COUNT_W - MODE_W - SPEED_W){1'b0}},
                         r_cycles, r_mode, r_val};
            r_m_user <= r_wr;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // Status back to the controller
    assign o_sts.mode        = r_mode;
    assign o_sts.expired     = (elapsed >= TIME_W'(delay));
    assign o_sts.arrived     = ($signed(r_pos) >= $signed(r_target));
    assign o_sts.zone_direct = (zone_nx == ZONE_CRUISE) || (zone_nx == ZONE_NONE);
    assign o_sts.div_busy    = div_busy;
    assign o_sts.out_free    = !r_m_valid || i_m_tready;

endmodule

[src/emps_ctrl.sv]
// ----------------------------------------------------------------------------
// emps_ctrl
// Controller: steps one item through mode decision, then while moving through
// progress, zone, eased-zone division and table read, multiply and finish, then output load.
// ----------------------------------------------------------------------------
module emps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  emps_pkg::t_dp_sts i_sts,
    output emps_pkg::t_dp_cmd o_cmd
);

    import emps_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_EVAL = 10'b0000000010,
        ST_PROG = 10'b0000000100,
        ST_ZONE = 10'b0000001000,
        ST_LOAD = 10'b0000010000,
        ST_DIV  = 10'b0000100000,
        ST_ROM  = 10'b0001000000,
        ST_MUL  = 10'b0010000000,
        ST_FIN  = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.mode == MODE_MOVING) begin
                    if (i_sts.arrived) begin
                        o_cmd.arrive = 1'b1;
                        n_state      = ST_OUT;
                    end else begin
                        o_cmd.calc_trav = 1'b1;
                        n_state         = ST_PROG;
                    end
                end else begin
                    if (i_sts.expired) begin
                        o_cmd.start_move = 1'b1;
                    end else begin
                        o_cmd.hold = 1'b1;
                    end
                    n_state = ST_OUT;
                end
            end
            ST_PROG: begin
                o_cmd.calc_prog = 1'b1;
                n_state         = ST_ZONE;
            end
            ST_ZONE: begin
                o_cmd.calc_zone = 1'b1;
                n_state         = i_sts.zone_direct ? ST_MUL : ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_ROM;
                end
            end
            ST_ROM: begin
                o_cmd.rom_rd = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/eased_motion_profile_sequencer_core.sv]
// Steps: startup, pause and arrival updates pass from item accept through the
// evaluate and output states; cruising adds progress, zone, multiply and finish;
// the eased zones add divider load, divide and table read, one quotient bit a cycle.
// Input: a new item is taken only once the previous result sits in the output
// register; the output state waits while that register is still full.
// Reset: synchronous, active low; restores register defaults, startup mode.
// ----------------------------------------------------------------------------
// eased_motion_profile_sequencer_core
// Startup delay, sine-eased moves of a set travel and timed pauses, one
// speed command result per position update.
// ----------------------------------------------------------------------------
module eased_motion_profile_sequencer_core #(
    parameter int SINE_TABLE_DEPTH = emps_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [emps_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // now_ms[31:0], position[63:32]
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [emps_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // speed_value[15:0], mode[17:16],
                                                           // cycles_done[49:18], zero[55:50]
    output logic                            m_axis_tuser,  // speed_write[0]
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [emps_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [emps_pkg::CFG_DATA_W-1:0] i_cfg_wr_data
);

    import emps_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    emps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    emps_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tdata     (s_axis_tdata),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

`ifndef SYNTH
    // One item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is still in work");

    // A result without a speed command carries speed zero
    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] == '0))
        else $error("speed value set without speed write");

    // Divider is started only when idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

    // Output register is loaded only when free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result overwritten before it was taken");
`endif

endmodule
